// ===== rtl/tad_pkg.sv =====
// ----------------------------------------------------------------------------
// tad_pkg
// Types and constants shared by the tar stream deframer and its checker.
// ----------------------------------------------------------------------------
package tad_pkg;

    localparam int unsigned BLOCK_BYTES = 512;
    localparam int unsigned OFF_W       = $clog2(BLOCK_BYTES);

    localparam logic [OFF_W-1:0] OFF_LAST   = OFF_W'(BLOCK_BYTES - 1);
    localparam logic [OFF_W-1:0] OFF_MODE   = OFF_W'(100);
    localparam logic [OFF_W-1:0] OFF_OWNER  = OFF_W'(108);
    localparam logic [OFF_W-1:0] OFF_GROUP  = OFF_W'(116);
    localparam logic [OFF_W-1:0] OFF_SIZE   = OFF_W'(124);
    localparam logic [OFF_W-1:0] OFF_MTIME  = OFF_W'(136);
    localparam logic [OFF_W-1:0] OFF_NUMEND = OFF_W'(148);
    localparam logic [OFF_W-1:0] OFF_TYPE   = OFF_W'(156);
    localparam logic [OFF_W-1:0] OFF_LINK   = OFF_W'(157);
    localparam logic [OFF_W-1:0] OFF_LINKEND = OFF_W'(257);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_TWO   = 8'h32;
    localparam logic [7:0] CH_FIVE  = 8'h35;

    localparam logic [2:0] KIND_NAME       = 3'd0;
    localparam logic [2:0] KIND_LINK       = 3'd1;
    localparam logic [2:0] KIND_CONTENT    = 3'd2;
    localparam logic [2:0] KIND_HEADER     = 3'd3;
    localparam logic [2:0] KIND_END_MARK   = 3'd4;
    localparam logic [2:0] KIND_STREAM_END = 3'd5;

    localparam logic [1:0] TYPE_REGULAR = 2'd0;
    localparam logic [1:0] TYPE_DIR     = 2'd1;
    localparam logic [1:0] TYPE_SYMLINK = 2'd2;

    localparam logic [2:0] ST_AFTER_MARK  = 3'd0;
    localparam logic [2:0] ST_BOUNDARY    = 3'd1;
    localparam logic [2:0] ST_MID_HEADER  = 3'd2;
    localparam logic [2:0] ST_MID_CONTENT = 3'd3;
    localparam logic [2:0] ST_MID_SKIP    = 3'd4;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       final_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  out_byte;
        logic [23:0] file_mode;
        logic [23:0] owner_id;
        logic [23:0] group_id;
        logic [35:0] file_size;
        logic [35:0] mod_time;
        logic [1:0]  entry_type;
        logic [2:0]  end_status;
        logic        last_of_run;
    } t_out_item;

endpackage

// ===== rtl/tar_archive_stream_deframer.sv =====
// ----------------------------------------------------------------------------
// tar_archive_stream_deframer
// Takes one archive byte per cycle unless stalled and emits name, link and
// content bytes, a decoded header record per header block, the end marker
// and a stream end item. Each accepted byte is parsed against the block
// offset and phase registers; its results (up to three) go into a four-entry
// result queue that drains one item per cycle unless the output stalls. A
// byte is accepted whenever at most one item waits in the queue, so with an
// unstalled output the block sustains one byte per cycle; a byte that yields
// two or three items (a held zero block released, a header record with the
// stream end) stalls the input while the queue's single read port drains them.
// ----------------------------------------------------------------------------
module tar_archive_stream_deframer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  tad_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output tad_pkg::t_out_item o_out_item
);
    import tad_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_HELD,
        PH_CONTENT,
        PH_SKIP,
        PH_PAD,
        PH_DONE
    } t_phase;

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned MAXRES = 3;

    t_phase           r_phase, n_phase;
    logic [OFF_W-1:0] r_offset, n_offset;
    logic [35:0]      r_remaining, n_remaining;
    logic [23:0]      r_mode, n_mode;
    logic [23:0]      r_owner, n_owner;
    logic [23:0]      r_group, n_group;
    logic [35:0]      r_size, n_size;
    logic [35:0]      r_mtime, n_mtime;
    logic [1:0]       r_type, n_type;
    logic             r_ended, n_ended;
    logic             r_nonzero, n_nonzero;

    t_out_item        r_fifo [QDEPTH];
    logic [1:0]       r_wr_ptr, r_rd_ptr;
    logic [2:0]       r_count;

    t_out_item        res [MAXRES];
    logic [1:0]       push_cnt;
    logic             in_acc, out_acc;
    logic             wrap, digit, link, region_text, region_num, fstart;
    logic [OFF_W-1:0] nxt_off;
    logic [7:0]       b;
    logic [2:0]       d;
    logic [2:0]       st;
    t_out_item        rec;

    assign o_in_stall  = (r_count > 3'd1);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_count != 3'd0);
    assign out_acc     = o_out_valid && !i_out_stall;
    assign o_out_item  = r_fifo[r_rd_ptr];

    always_comb begin
        b           = i_in_item.byte_value;
        d           = b[2:0];
        digit       = (b >= CH_ZERO) && (b <= CH_SEVEN);
        wrap        = (r_offset == OFF_LAST);
        nxt_off     = wrap ? '0 : r_offset + OFF_W'(1);
        region_text = (r_offset < OFF_MODE) ||
                      ((r_offset >= OFF_LINK) && (r_offset < OFF_LINKEND));
        region_num  = (r_offset >= OFF_MODE) && (r_offset < OFF_NUMEND);
        link        = (r_offset >= OFF_LINK);
        fstart      = (r_offset == '0) || (r_offset == OFF_MODE) ||
                      (r_offset == OFF_OWNER) || (r_offset == OFF_GROUP) ||
                      (r_offset == OFF_SIZE) || (r_offset == OFF_MTIME) ||
                      (r_offset == OFF_LINK);
        st          = ST_AFTER_MARK;
        rec         = '0;

        n_phase     = r_phase;
        n_offset    = r_offset;
        n_remaining = r_remaining;
        n_mode      = r_mode;
        n_owner     = r_owner;
        n_group     = r_group;
        n_size      = r_size;
        n_mtime     = r_mtime;
        n_type      = r_type;
        n_ended     = r_ended;
        n_nonzero   = r_nonzero;

        for (int i = 0; i < MAXRES; i++) begin
            res[i] = '0;
        end
        push_cnt = 2'd0;

        unique case (r_phase)
            PH_HEADER, PH_HELD: begin
                if (r_phase == PH_HEADER && r_offset == '0) begin
                    n_mode = '0; n_owner = '0; n_group = '0;
                    n_size = '0; n_mtime = '0; n_type = TYPE_REGULAR;
                    n_ended = 1'b0; n_nonzero = 1'b0;
                end
                if (r_phase == PH_HELD && b != CH_NUL) begin
                    res[push_cnt].kind = KIND_HEADER;
                    push_cnt = push_cnt + 2'd1;
                    n_phase = PH_HEADER;
                end
                if (fstart) begin
                    n_ended = 1'b0;
                end
                if (b != CH_NUL) begin
                    n_nonzero = 1'b1;
                end
                if (region_text) begin
                    if (!(link && n_type != TYPE_SYMLINK) && !n_ended) begin
                        if (b == CH_NUL) begin
                            n_ended = 1'b1;
                        end else begin
                            res[push_cnt].kind     = link ? KIND_LINK : KIND_NAME;
                            res[push_cnt].out_byte = b;
                            push_cnt = push_cnt + 2'd1;
                        end
                    end
                end else if (region_num) begin
                    if (!n_ended) begin
                        if (b == CH_NUL) begin
                            n_ended = 1'b1;
                        end else if (digit) begin
                            if (r_offset < OFF_OWNER) begin
                                n_mode = {n_mode[20:0], d};
                            end else if (r_offset < OFF_GROUP) begin
                                n_owner = {n_owner[20:0], d};
                            end else if (r_offset < OFF_SIZE) begin
                                n_group = {n_group[20:0], d};
                            end else if (r_offset < OFF_MTIME) begin
                                n_size = {n_size[32:0], d};
                            end else begin
                                n_mtime = {n_mtime[32:0], d};
                            end
                        end
                    end
                end else if (r_offset == OFF_TYPE) begin
                    n_type = (b == CH_FIVE) ? TYPE_DIR :
                             (b == CH_TWO)  ? TYPE_SYMLINK : TYPE_REGULAR;
                end
                n_offset = nxt_off;
                if (wrap) begin
                    if (n_phase == PH_HELD) begin
                        res[push_cnt].kind = KIND_END_MARK;
                        push_cnt = push_cnt + 2'd1;
                        n_phase = PH_DONE;
                    end else begin
                        if (n_nonzero) begin
                            rec.kind       = KIND_HEADER;
                            rec.file_mode  = n_mode;
                            rec.owner_id   = n_owner;
                            rec.group_id   = n_group;
                            rec.file_size  = n_size;
                            rec.mod_time   = n_mtime;
                            rec.entry_type = n_type;
                            res[push_cnt]  = rec;
                            push_cnt = push_cnt + 2'd1;
                            n_remaining = n_size;
                            if (n_size == '0) begin
                                n_phase = PH_HEADER;
                            end else if (n_type == TYPE_REGULAR) begin
                                n_phase = PH_CONTENT;
                            end else begin
                                n_phase = PH_SKIP;
                            end
                        end else begin
                            n_phase = PH_HELD;
                        end
                        n_mode = '0; n_owner = '0; n_group = '0;
                        n_size = '0; n_mtime = '0; n_type = TYPE_REGULAR;
                        n_ended = 1'b0; n_nonzero = 1'b0;
                    end
                end
            end
            PH_CONTENT, PH_SKIP: begin
                if (r_phase == PH_CONTENT) begin
                    res[push_cnt].kind     = KIND_CONTENT;
                    res[push_cnt].out_byte = b;
                    push_cnt = push_cnt + 2'd1;
                end
                if (r_remaining != '0) begin
                    n_remaining = r_remaining - 36'd1;
                end
                n_offset = nxt_off;
                if (n_remaining == '0) begin
                    n_phase = wrap ? PH_HEADER : PH_PAD;
                end
            end
            PH_PAD: begin
                n_offset = nxt_off;
                if (wrap) begin
                    n_phase = PH_HEADER;
                end
            end
            default: begin
            end
        endcase

        if (i_in_item.final_byte) begin
            if (n_phase == PH_HELD) begin
                res[push_cnt].kind = KIND_HEADER;
                push_cnt = push_cnt + 2'd1;
            end
            case (n_phase)
                PH_DONE:              st = ST_AFTER_MARK;
                PH_HEADER, PH_HELD:   st = (n_offset == '0) ? ST_BOUNDARY : ST_MID_HEADER;
                PH_CONTENT:           st = ST_MID_CONTENT;
                default:              st = ST_MID_SKIP;
            endcase
            res[push_cnt].kind       = KIND_STREAM_END;
            res[push_cnt].end_status = st;
            push_cnt = push_cnt + 2'd1;
            n_phase     = PH_HEADER;
            n_offset    = '0;
            n_remaining = '0;
            n_mode = '0; n_owner = '0; n_group = '0;
            n_size = '0; n_mtime = '0; n_type = TYPE_REGULAR;
            n_ended = 1'b0; n_nonzero = 1'b0;
        end

        if (push_cnt != 2'd0) begin
            res[push_cnt - 2'd1].last_of_run = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_offset    <= '0;
            r_remaining <= '0;
            r_mode      <= '0;
            r_owner     <= '0;
            r_group     <= '0;
            r_size      <= '0;
            r_mtime     <= '0;
            r_type      <= TYPE_REGULAR;
            r_ended     <= 1'b0;
            r_nonzero   <= 1'b0;
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_count     <= '0;
        end else begin
            if (in_acc) begin
                r_phase     <= n_phase;
                r_offset    <= n_offset;
                r_remaining <= n_remaining;
                r_mode      <= n_mode;
                r_owner     <= n_owner;
                r_group     <= n_group;
                r_size      <= n_size;
                r_mtime     <= n_mtime;
                r_type      <= n_type;
                r_ended     <= n_ended;
                r_nonzero   <= n_nonzero;
                r_wr_ptr    <= r_wr_ptr + push_cnt;
            end
            if (out_acc) begin
                r_rd_ptr <= r_rd_ptr + 2'd1;
            end
            r_count <= r_count + (in_acc ? {1'b0, push_cnt} : 3'd0)
                               - (out_acc ? 3'd1 : 3'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAXRES; i++) begin
            if (in_acc && (2'(i) < push_cnt)) begin
                r_fifo[r_wr_ptr + 2'(i)] <= res[i];
            end
        end
    end

endmodule

// ===== rtl/tad_checker.sv =====
// ----------------------------------------------------------------------------
// tad_checker
// Port-level checks for the tar stream deframer, bound to the top level.
// ----------------------------------------------------------------------------
module tad_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input tad_pkg::t_in_item  i_in_item,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input tad_pkg::t_out_item o_out_item
);
    import tad_pkg::*;

    a_in_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |-> !$isunknown(i_in_item))
        else $error("accepted input item has unknown bits");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output valid dropped while stalled");

    a_item_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_item))
        else $error("stalled output item changed");

    a_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.kind != KIND_HEADER |->
            o_out_item.file_size == '0 && o_out_item.mod_time == '0 &&
            o_out_item.file_mode == '0 && o_out_item.entry_type == TYPE_REGULAR)
        else $error("header fields set outside a header record");

    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.kind == KIND_STREAM_END |-> o_out_item.last_of_run)
        else $error("stream end not last item of its byte");

endmodule

bind tar_archive_stream_deframer tad_checker u_tad_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
